### rtl/core/sced_pkg.sv
// Package for the combined Sobel edge filter: item types, register map and
// sizing constants. It depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps

package sced_pkg;

  // Default for the longest image row that the line memory can hold.
  localparam int MaxWidthDef = 1024;

  // Configuration register map.
  localparam int          PaddrW        = 3;
  localparam int          PdataW        = 32;
  localparam logic        RegLineWidth  = 1'b0;
  localparam int          LineWidthW    = 11;
  localparam logic [10:0] LineWidthRst  = 11'd640;
  localparam logic [10:0] MinWidth      = 11'd3;

  // Row counter saturates once two full rows lie above the current one.
  localparam logic [1:0] RowFull = 2'd2;

  // Depth of the result queue in front of the output port.
  localparam int OutDepth = 3;

  // One input item.
  typedef struct packed {
    logic [7:0] gray_pixel;
    logic       frame_start;
  } sced_pix_t;

  // One result item.
  typedef struct packed {
    logic [7:0] edge_value;
    logic       window_inside;
  } sced_res_t;

  // One word of the line memory: the two stored rows at one column.
  typedef struct packed {
    logic [7:0] upper;
    logic [7:0] middle;
  } sced_line_t;

  // An item handed from the column control to the gradient stage.
  typedef struct packed {
    logic       valid;
    logic [7:0] pixel;
    logic       in_frame;
    logic       stored;
    logic       fwd;
  } sced_issue_t;

endpackage

### rtl/core/sobel_combined_edge_filter.sv
// Combined 3x3 Sobel edge filter over a raster stream of 8-bit gray pixels.
// Throughput: one item per clock while the input is not stalled; the line
// memory is read once and written once per item, and a write is forwarded
// to a read of the same column; the issue register feeds the result queue.
// Reset: counters and the width register (640) clear at once; the line
// memory needs no clearing pass, as a fill mark covers unwritten columns.
`timescale 1ns / 1ps

module sobel_combined_edge_filter import sced_pkg::*; #(
  parameter int MAX_WIDTH = MaxWidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Pixel input
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sced_pix_t         in_item_i,
  // Result output
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sced_res_t         out_item_o,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  localparam int ColW = $clog2(MAX_WIDTH);

  logic [LineWidthW-1:0] line_width_q;
  logic                  cfg_wr;
  logic                  rd_en;
  logic [ColW-1:0]       rd_addr;
  logic [ColW-1:0]       wr_addr;
  sced_issue_t           issue;
  sced_line_t            rd_data;
  logic                  we;
  sced_line_t            wdata;
  logic                  push;
  sced_res_t             res;
  logic                  full;

  // Configuration register.
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == RegLineWidth);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LineWidthRst;
    end else if (cfg_wr) begin
      line_width_q <= pwdata[LineWidthW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegLineWidth) ? PdataW'(line_width_q) : '0;

  // Input stalls only when the result queue cannot take another item.
  assign in_stall_o = full;

  sced_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (full),
    .in_item_i    (in_item_i),
    .line_width_i (line_width_q),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .wr_addr_o    (wr_addr),
    .issue_o      (issue)
  );

  sced_line_mem #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wr_addr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  sced_grad u_grad (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .issue_i   (issue),
    .rd_data_i (rd_data),
    .we_o      (we),
    .wdata_o   (wdata),
    .push_o    (push),
    .res_o     (res)
  );

  sced_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (res),
    .inflight_i  (issue.valid),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

### rtl/core/sced_line_mem.sv
// Line memory of the edge filter: one word per column, holding the rows two
// above and one above the current one. Depends on sced_pkg.
`timescale 1ns / 1ps

module sced_line_mem import sced_pkg::*; #(
  parameter int MAX_WIDTH = MaxWidthDef
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] waddr_i,
  input  sced_line_t                   wdata_i,
  input  logic                         re_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] raddr_i,
  output sced_line_t                   rdata_o
);

  sced_line_t mem_q [MAX_WIDTH];
  sced_line_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/sced_ctrl.sv
// Column and row control of the edge filter: tracks the raster position,
// issues line memory reads and flags forwarding and unwritten entries.
// Depends on sced_pkg.
`timescale 1ns / 1ps

module sced_ctrl import sced_pkg::*; #(
  parameter int MAX_WIDTH = MaxWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  sced_pix_t                    in_item_i,
  input  logic [LineWidthW-1:0]        line_width_i,
  output logic                         rd_en_o,
  output logic [$clog2(MAX_WIDTH)-1:0] rd_addr_o,
  output logic [$clog2(MAX_WIDTH)-1:0] wr_addr_o,
  output sced_issue_t                  issue_o
);

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int CntW = $clog2(MAX_WIDTH + 1);
  localparam int CmpW = (CntW > LineWidthW) ? CntW : LineWidthW;

  logic            accept;
  logic [CmpW-1:0] lw_ext;
  logic [CmpW-1:0] w_use;
  logic [ColW-1:0] col_start;
  logic [1:0]      row_start;
  logic [ColW-1:0] col;
  logic [1:0]      row;
  logic [CmpW-1:0] nxt;
  logic [ColW-1:0] col_q, col_d;
  logic [1:0]      row_q, row_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [ColW-1:0] last_col_q;
  logic            last_acc_q;
  sced_issue_t     issue_q, issue_d;

  assign accept = in_valid_i && !in_stall_i;

  // Row width in use, kept between MinWidth and the line memory size.
  always_comb begin
    lw_ext = CmpW'(line_width_i);
    if (lw_ext < CmpW'(MinWidth)) begin
      w_use = CmpW'(MinWidth);
    end else if (lw_ext > CmpW'(MAX_WIDTH)) begin
      w_use = CmpW'(MAX_WIDTH);
    end else begin
      w_use = lw_ext;
    end
  end

  // Position of the incoming pixel and of the one after it.
  always_comb begin
    col_start = in_item_i.frame_start ? '0 : col_q;
    row_start = in_item_i.frame_start ? '0 : row_q;
    col       = col_start;
    row       = row_start;
    // A row cut short by a lower width is taken as complete.
    if (CmpW'(col_start) >= w_use) begin
      col = '0;
      row = (row_start == RowFull) ? RowFull : row_start + 2'd1;
    end
    nxt   = CmpW'(col) + CmpW'(1);
    col_d = nxt[ColW-1:0];
    row_d = row;
    if (nxt >= w_use) begin
      col_d = '0;
      row_d = (row == RowFull) ? RowFull : row + 2'd1;
    end
  end

  // Entries are written in column order from reset, so those below the
  // fill mark are exactly the ones ever written.
  assign fill_d = (CntW'(col) == fill_q) ? fill_q + CntW'(1) : fill_q;

  // Item handed to the gradient stage.
  always_comb begin
    issue_d.valid    = accept;
    issue_d.pixel    = in_item_i.gray_pixel;
    issue_d.in_frame = (row == RowFull) && (col >= ColW'(2));
    issue_d.stored   = CntW'(col) < fill_q;
    // The previous item writes this same column at this edge.
    issue_d.fwd      = last_acc_q && (last_col_q == col);
  end

  // Position and fill state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      fill_q     <= '0;
      last_col_q <= '0;
      last_acc_q <= 1'b0;
      issue_q    <= '0;
    end else begin
      last_acc_q <= accept;
      issue_q    <= issue_d;
      if (accept) begin
        col_q      <= col_d;
        row_q      <= row_d;
        fill_q     <= fill_d;
        last_col_q <= col;
      end
    end
  end

  assign rd_en_o   = accept;
  assign rd_addr_o = col;
  assign wr_addr_o = last_col_q;
  assign issue_o   = issue_q;

endmodule

### rtl/core/sced_grad.sv
// Gradient stage of the edge filter: merges line memory data with forwarded
// writes, holds the window registers and forms the saturated edge value.
// Depends on sced_pkg.
`timescale 1ns / 1ps

module sced_grad import sced_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sced_issue_t issue_i,
  input  sced_line_t  rd_data_i,
  output logic        we_o,
  output sced_line_t  wdata_o,
  output logic        push_o,
  output sced_res_t   res_o
);

  logic [7:0]  top, mid;
  logic [7:0]  fwd_top_q, fwd_mid_q;
  // Top c-1, top c-2, middle c-1, middle c-2, bottom c-1.
  logic [7:0]  top1_q, top2_q, mid1_q, mid2_q, bot1_q;
  logic [10:0] sum;
  logic [10:0] mag_abs;
  logic [7:0]  mag;

  // Column data: forwarded from the previous item, read, or never written.
  always_comb begin
    if (issue_i.fwd) begin
      top = fwd_top_q;
      mid = fwd_mid_q;
    end else if (issue_i.stored) begin
      top = rd_data_i.upper;
      mid = rd_data_i.middle;
    end else begin
      top = '0;
      mid = '0;
    end
  end

  // Combined gradient: TL + TC + CL - BC - CR - BR, in two's complement.
  always_comb begin
    sum = 11'(top2_q) + 11'(top1_q) + 11'(mid2_q)
        - 11'(bot1_q) - 11'(mid) - 11'(issue_i.pixel);
    mag_abs = sum[10] ? 11'(-sum) : sum;
    // Twice the magnitude, saturated to the 8-bit range.
    mag = (|mag_abs[10:7]) ? 8'hFF : {mag_abs[6:0], 1'b0};
  end

  // Window shift and forwarding copies of this item's write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top1_q    <= '0;
      top2_q    <= '0;
      mid1_q    <= '0;
      mid2_q    <= '0;
      bot1_q    <= '0;
      fwd_top_q <= '0;
      fwd_mid_q <= '0;
    end else if (issue_i.valid) begin
      top2_q    <= top1_q;
      top1_q    <= top;
      mid2_q    <= mid1_q;
      mid1_q    <= mid;
      bot1_q    <= issue_i.pixel;
      fwd_top_q <= mid;
      fwd_mid_q <= issue_i.pixel;
    end
  end

  assign we_o           = issue_i.valid;
  assign wdata_o.upper  = mid;
  assign wdata_o.middle = issue_i.pixel;

  assign push_o              = issue_i.valid;
  assign res_o.edge_value    = issue_i.in_frame ? mag : 8'd0;
  assign res_o.window_inside = issue_i.in_frame;

endmodule

### rtl/core/sced_out_fifo.sv
// Result queue of the edge filter: a short queue between the gradient stage
// and the output port, with a full flag built from registers only.
// Depends on sced_pkg.
`timescale 1ns / 1ps

module sced_out_fifo import sced_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  sced_res_t push_item_i,
  input  logic      inflight_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output sced_res_t out_item_o
);

  localparam int PtrW = $clog2(OutDepth);
  localparam int CntW = $clog2(OutDepth + 1);

  sced_res_t       entry_q [OutDepth];
  logic [PtrW-1:0] head_q, tail_q;
  logic [CntW-1:0] count_q;
  logic            pop;

  assign pop = (count_q != '0) && !out_stall_i;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[tail_q] <= push_item_i;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        tail_q <= (tail_q == PtrW'(OutDepth - 1)) ? '0 : tail_q + PtrW'(1);
      end
      if (pop) begin
        head_q <= (head_q == PtrW'(OutDepth - 1)) ? '0 : head_q + PtrW'(1);
      end
      count_q <= count_q + CntW'(push_i) - CntW'(pop);
    end
  end

  // Room for the item in flight and one more accepted this cycle.
  assign full_o = (count_q == CntW'(OutDepth))
               || (inflight_i && (count_q == CntW'(OutDepth - 1)));

  assign out_valid_o = count_q != '0;
  assign out_item_o  = entry_q[head_q];

endmodule
